// ===== src/hta_pkg.sv =====
package hta_pkg;

  localparam int MODE_W   = 2;
  localparam int POS_W    = 10;
  localparam int RAD_W    = 6;
  localparam int PEAK_W   = 18;
  localparam int CELL_W   = 17;
  localparam int CFG_W    = 9;
  localparam int R2_W     = 12;
  localparam int PROD_W   = PEAK_W + R2_W;
  localparam int COORD_W  = 14;
  localparam int DIFF_W   = 7;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int H_W      = 15;
  localparam int DCNT_W   = 5;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HILL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic [CELL_W-1:0] ONE_FIXED = 17'h10000;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [COORD_W-1:0] cr;
    logic signed [COORD_W-1:0] cc;
    logic signed [COORD_W-1:0] row_lo;
    logic signed [COORD_W-1:0] row_end;
    logic signed [COORD_W-1:0] col_lo;
    logic signed [COORD_W-1:0] col_end;
    logic [RAD_W-1:0]          rad;
    logic [R2_W-1:0]           r2;
    logic [PEAK_W-1:0]         peak;
  } hta_cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] rows;
    logic [COORD_W-1:0] cols;
  } hta_size_t;

endpackage

// ===== src/hta_in_if.sv =====
interface hta_in_if;
  logic                                valid;
  logic                                ready;
  logic [hta_pkg::MODE_W-1:0]          mode;
  logic signed [hta_pkg::POS_W-1:0]    center_row;
  logic signed [hta_pkg::POS_W-1:0]    center_col;
  logic [hta_pkg::RAD_W-1:0]           radius;
  logic [hta_pkg::PEAK_W-1:0]          peak_height;

  modport source (output valid, mode, center_row, center_col, radius, peak_height,
                  input ready);
  modport sink (input valid, mode, center_row, center_col, radius, peak_height,
                output ready);
endinterface

// ===== src/hta_out_if.sv =====
interface hta_out_if;
  logic                         valid;
  logic                         ready;
  logic [hta_pkg::CELL_W-1:0]   cell_height;
  logic [hta_pkg::MODE_W-1:0]   done_mode;

  modport source (output valid, cell_height, done_mode, input ready);
  modport sink (input valid, cell_height, done_mode, output ready);
endinterface

// ===== src/hta_cfg_if.sv =====
interface hta_cfg_if;
  logic                       valid;
  logic                       ready;
  logic                       index;
  logic [hta_pkg::CFG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/hill_terrain_accumulator_unit.sv =====
// Channel  | Dir | Payload                                           | Handshake
// in_ch    | in  | mode, center_row, center_col, radius, peak_height | valid/ready
// out_ch   | out | cell_height, done_mode                            | valid/ready
// cfg_ch   | in  | index (0 rows_in_use, 1 cols_in_use), data        | valid/ready
//
// Each in_ch transaction yields one out_ch transaction, in order. A clear writes one cell
// per cycle on the single memory port. A hill visits 4*R^2 cells: a skipped cell is only
// checked; an updated cell goes through a check, a multiply, 18 steps of the bit-serial
// divider and a write. After reset a clearing pass over the whole memory holds in_ch
// not ready.
// cfg_ch is always ready; a two-entry queue keeps in_ch open while the back end is busy.
module hill_terrain_accumulator_unit #(
  parameter int GRID_ROWS  = 256,
  parameter int GRID_COLS  = 256,
  parameter int MAX_RADIUS = 63
) (
  input  logic      clk,
  input  logic      rst,
  hta_in_if.sink    in_ch,
  hta_out_if.source out_ch,
  hta_cfg_if.sink   cfg_ch
);
  import hta_pkg::*;

  logic [CFG_W-1:0] rows_in_use;
  logic [CFG_W-1:0] cols_in_use;
  hta_size_t        size;
  hta_cmd_t         cmd;
  logic             cmd_valid;
  logic             cmd_ready;
  logic             init_busy;

  // Configuration writes must arrive only while the block is idle (the user's
  // duty; the block does not enforce it). They are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CFG_W'(256);
      cols_in_use <= CFG_W'(256);
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_ROWS) rows_in_use <= cfg_ch.data;
      if (cfg_ch.index == CFG_COLS) cols_in_use <= cfg_ch.data;
    end
  end

  // The effective size is the register clamped to the grid that is built.
  always_comb begin
    size.rows = (32'(rows_in_use) > GRID_ROWS) ? COORD_W'(GRID_ROWS)
                                                : COORD_W'(rows_in_use);
    size.cols = (32'(cols_in_use) > GRID_COLS) ? COORD_W'(GRID_COLS)
                                                : COORD_W'(cols_in_use);
  end

  hta_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (init_busy),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  hta_back #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_in    (cmd),
    .size      (size),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

  // No transaction is taken while the grid is still being cleared.
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !in_ch.ready)
    else $error("input accepted during clearing pass");

  // Only a read returns a nonzero height.
  a_height_only_read: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.done_mode != MODE_READ) |-> out_ch.cell_height == '0)
    else $error("nonzero height on a result that is not a read");

  // Stored heights saturate at one.
  a_height_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.cell_height <= ONE_FIXED)
    else $error("cell height above saturation");
endmodule

// ===== src/hta_ram.sv =====
module hta_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end
endmodule

// ===== src/hta_front.sv =====
module hta_front #(
  parameter int MAX_RADIUS = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              hold,
  hta_in_if.sink            in_ch,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output hta_pkg::hta_cmd_t cmd
);
  import hta_pkg::*;

  hta_cmd_t         fifo [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  hta_cmd_t         new_cmd;
  logic [RAD_W-1:0] rad;
  logic             push;
  logic             pop;

  // Radius is clamped to the largest supported hill and the scan bounds are
  // worked out here, so the back end only walks counters.
  always_comb begin
    rad = (32'(in_ch.radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : in_ch.radius;
    new_cmd.mode    = in_ch.mode;
    new_cmd.cr      = COORD_W'(in_ch.center_row);
    new_cmd.cc      = COORD_W'(in_ch.center_col);
    new_cmd.rad     = rad;
    new_cmd.r2      = R2_W'(rad) * R2_W'(rad);
    new_cmd.peak    = in_ch.peak_height;
    new_cmd.row_lo  = new_cmd.cr - $signed({{(COORD_W-RAD_W){1'b0}}, rad});
    new_cmd.row_end = new_cmd.cr + $signed({{(COORD_W-RAD_W){1'b0}}, rad});
    new_cmd.col_lo  = new_cmd.cc - $signed({{(COORD_W-RAD_W){1'b0}}, rad});
    new_cmd.col_end = new_cmd.cc + $signed({{(COORD_W-RAD_W){1'b0}}, rad});
  end

  assign in_ch.ready = (count != 2'd2) && !hold;
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (count != 2'd0);
  assign cmd         = fifo[rd_ptr];
  assign pop         = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= new_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== src/hta_back.sv =====
module hta_back #(
  parameter int GRID_ROWS = 256,
  parameter int GRID_COLS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  hta_pkg::hta_cmd_t  cmd_in,
  input  hta_pkg::hta_size_t size,
  output logic               init_busy,
  hta_out_if.source          out_ch
);
  import hta_pkg::*;

  localparam int RW     = $clog2(GRID_ROWS);
  localparam int CW     = $clog2(GRID_COLS);
  localparam int ADDR_W = RW + CW;
  localparam int DEPTH  = 1 << ADDR_W;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_CELL  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_WRITE = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_RDATA = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]                st;
  logic [ADDR_W-1:0]         sweep;
  hta_cmd_t                  cmd;
  logic signed [COORD_W-1:0] row;
  logic signed [COORD_W-1:0] col;
  logic [R2_W-1:0]           h_reg;
  logic [R2_W-1:0]           rem;
  logic [PEAK_W-1:0]         qsh;
  logic [DCNT_W-1:0]         dcnt;
  logic [CELL_W-1:0]         res;
  logic                      ovalid;
  logic [CELL_W-1:0]         ocell;
  logic [MODE_W-1:0]         omode;

  logic signed [COORD_W-1:0] dx_w, dy_w;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic signed [SQ_W-1:0]    dxsq, dysq;
  logic signed [H_W-1:0]     hval;
  logic                      row_in, col_in, rd_row_in, rd_col_in;
  logic signed [COORD_W-1:0] col_inc, row_inc;
  logic                      last_col, last_row;
  logic [PROD_W-1:0]         prod;
  logic [R2_W:0]             trial;
  logic                      ge;
  logic [PEAK_W:0]           sum;
  logic [CELL_W-1:0]         sat;
  logic                      ram_en, ram_we;
  logic [ADDR_W-1:0]         ram_addr;
  logic [CELL_W-1:0]         ram_wdata, ram_rdata;

  always_comb begin
    dx_w      = cmd.cc - col;
    dy_w      = cmd.cr - row;
    dx        = dx_w[DIFF_W-1:0];
    dy        = dy_w[DIFF_W-1:0];
    dxsq      = dx * dx;
    dysq      = dy * dy;
    hval      = $signed({{(H_W-R2_W){1'b0}}, cmd.r2}) - H_W'(dxsq) - H_W'(dysq);
    row_in    = (row >= 0) && (row < $signed(size.rows));
    col_in    = (col >= 0) && (col < $signed(size.cols));
    rd_row_in = (cmd.cr >= 0) && (cmd.cr < $signed(size.rows));
    rd_col_in = (cmd.cc >= 0) && (cmd.cc < $signed(size.cols));
    col_inc   = col + COORD_W'(1);
    row_inc   = row + COORD_W'(1);
    last_col  = (col_inc == cmd.col_end);
    last_row  = (row_inc == cmd.row_end);
    prod      = PROD_W'(cmd.peak) * PROD_W'(h_reg);
    trial     = {rem, qsh[PEAK_W-1]};
    ge        = (trial >= {1'b0, cmd.r2});
    sum       = (PEAK_W+1)'(ram_rdata) + (PEAK_W+1)'(qsh);
    sat       = (sum > (PEAK_W+1)'(ONE_FIXED)) ? ONE_FIXED : sum[CELL_W-1:0];
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = {row[RW-1:0], col[CW-1:0]};
    ram_wdata = sat;
    case (st)
      S_INIT, S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = sweep;
        ram_wdata = '0;
      end
      S_MUL: ram_en = 1'b1;
      S_WRITE: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
      end
      S_READ: begin
        ram_en   = rd_row_in && rd_col_in;
        ram_addr = {cmd.cr[RW-1:0], cmd.cc[CW-1:0]};
      end
      default: ;
    endcase
  end

  hta_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign cmd_ready          = (st == S_IDLE);
  assign init_busy          = (st == S_INIT);
  assign out_ch.valid       = ovalid;
  assign out_ch.cell_height = ocell;
  assign out_ch.done_mode   = omode;

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_INIT;
      sweep  <= '0;
      ovalid <= 1'b0;
    end else begin
      if ((st == S_DONE) && (!ovalid || out_ch.ready)) begin
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
      case (st)
        S_INIT, S_CLEAR: begin
          sweep <= sweep + ADDR_W'(1);
          if (sweep == ADDR_W'(DEPTH - 1)) begin
            st <= (st == S_INIT) ? S_IDLE : S_DONE;
          end
        end
        S_IDLE: begin
          res <= '0;
          if (cmd_valid) begin
            cmd <= cmd_in;
            row <= cmd_in.row_lo;
            col <= cmd_in.col_lo;
            case (cmd_in.mode)
              MODE_CLEAR: begin
                sweep <= '0;
                st    <= S_CLEAR;
              end
              MODE_HILL: st <= (cmd_in.rad == '0) ? S_DONE : S_CELL;
              MODE_READ: st <= S_READ;
              default:   st <= S_DONE;
            endcase
          end
        end
        S_CELL: begin
          if (row_in && col_in && !hval[H_W-1]) begin
            h_reg <= hval[R2_W-1:0];
            st    <= S_MUL;
          end else if (last_col) begin
            col <= cmd.col_lo;
            row <= row_inc;
            if (last_row) st <= S_DONE;
          end else begin
            col <= col_inc;
          end
        end
        S_MUL: begin
          rem  <= prod[PROD_W-1:PEAK_W];
          qsh  <= prod[PEAK_W-1:0];
          dcnt <= '0;
          st   <= S_DIV;
        end
        S_DIV: begin
          rem  <= ge ? R2_W'(trial - {1'b0, cmd.r2}) : trial[R2_W-1:0];
          qsh  <= {qsh[PEAK_W-2:0], ge};
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(PEAK_W - 1)) st <= S_WRITE;
        end
        S_WRITE: begin
          if (last_col) begin
            col <= cmd.col_lo;
            row <= row_inc;
            st  <= last_row ? S_DONE : S_CELL;
          end else begin
            col <= col_inc;
            st  <= S_CELL;
          end
        end
        S_READ: st <= (rd_row_in && rd_col_in) ? S_RDATA : S_DONE;
        S_RDATA: begin
          res <= ram_rdata;
          st  <= S_DONE;
        end
        S_DONE: begin
          if (!ovalid || out_ch.ready) begin
            ocell  <= res;
            omode  <= cmd.mode;
            st     <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== dv/hta_tb_if.sv =====
`timescale 1ns / 100ps
// The channel interfaces come from the RTL; this file only holds the
// transaction types that the testbench keeps in its queues.
package hta_tb_pkg;
  import hta_pkg::*;

  typedef struct {
    logic [CELL_W-1:0] height;
    logic [MODE_W-1:0] mode;
  } cell_result_t;

endpackage

// ===== dv/tb_hill_terrain_accumulator_unit.sv =====
`timescale 1ns / 100ps
module tb_hill_terrain_accumulator_unit;
  import hta_pkg::*;
  import hta_tb_pkg::*;

  localparam int ROWS = 256;
  localparam int COLS = 256;
  localparam int RAD_MAX = 63;
  // The longest legal quiet period is one maximal hill (4*R^2 cells, each
  // updated through the divider) or one clear; the limit is several times that.
  localparam int QUIET_LIMIT = 2000000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hta_in_if  in_ch ();
  hta_out_if out_ch ();
  hta_cfg_if cfg_ch ();

  hill_terrain_accumulator_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: our own copy of the grid and of the two size registers.
  logic [CELL_W-1:0] grid_model [0:ROWS*COLS-1];
  logic [CFG_W-1:0]  rows_reg;
  logic [CFG_W-1:0]  cols_reg;

  cell_result_t expected_cells[$];
  int errors = 0;
  int mismatches = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  function automatic int used_rows();
    return (rows_reg > ROWS) ? ROWS : int'(rows_reg);
  endfunction

  function automatic int used_cols();
    return (cols_reg > COLS) ? COLS : int'(cols_reg);
  endfunction

  // Raise one hill on the model grid. The footprint is the half-open square
  // around the center; cells with a negative profile are left alone.
  task automatic raise_hill(int cr, int cc, int rad, longint peak);
    longint r2, dx, dy, h, add, sum;
    int nr, nc;
    nr = used_rows();
    nc = used_cols();
    r2 = longint'(rad) * rad;
    if (rad == 0) return;
    for (int r = cr - rad; r < cr + rad; r++) begin
      if (r < 0 || r >= nr) continue;
      for (int c = cc - rad; c < cc + rad; c++) begin
        if (c < 0 || c >= nc) continue;
        dx = cc - c;
        dy = cr - r;
        h = r2 - dx * dx - dy * dy;
        if (h < 0) continue;
        add = (peak * h) / r2;
        sum = longint'(grid_model[r * COLS + c]) + add;
        grid_model[r * COLS + c] = (sum > longint'(ONE_FIXED)) ? ONE_FIXED : sum[CELL_W-1:0];
      end
    end
  endtask

  // Work out the result of one accepted item and update the model grid.
  task automatic predict_cell(logic [MODE_W-1:0] mode, logic signed [POS_W-1:0] row,
                              logic signed [POS_W-1:0] col, logic [RAD_W-1:0] rad,
                              logic [PEAK_W-1:0] peak);
    cell_result_t res;
    int cr, cc, r;
    cr = int'(row);
    cc = int'(col);
    r = (rad > RAD_MAX) ? RAD_MAX : int'(rad);
    res.height = '0;
    res.mode = mode;
    case (mode)
      MODE_CLEAR: begin
        foreach (grid_model[i]) grid_model[i] = '0;
      end
      MODE_HILL: begin
        raise_hill(cr, cc, r, longint'(peak));
      end
      MODE_READ: begin
        if (cr >= 0 && cr < used_rows() && cc >= 0 && cc < used_cols())
          res.height = grid_model[cr * COLS + cc];
      end
      default: begin
      end
    endcase
    expected_cells.push_back(res);
  endtask

  // Sender: offers one item, possibly after a short random gap, and waits
  // for the transaction. Valid stays high into the next call when no gap.
  task automatic send_item(logic [MODE_W-1:0] mode, logic signed [POS_W-1:0] row,
                           logic signed [POS_W-1:0] col, logic [RAD_W-1:0] rad,
                           logic [PEAK_W-1:0] peak);
    int gap;
    gap = (no_idle || $urandom_range(0, 99) >= 25) ? 0 : $urandom_range(1, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.mode        = mode;
    in_ch.center_row  = row;
    in_ch.center_col  = col;
    in_ch.radius      = rad;
    in_ch.peak_height = peak;
    do @(posedge clk); while (!in_ch.ready);
    predict_cell(mode, row, col, rad, peak);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (expected_cells.size() == 0);
    repeat (30) @(negedge clk);
  endtask

  // Register writes happen only with nothing in flight.
  task automatic write_size(logic idx, logic [CFG_W-1:0] value);
    drain();
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_ROWS) rows_reg = value;
    else cols_reg = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic read_cell(int row, int col);
    send_item(MODE_READ, row[POS_W-1:0], col[POS_W-1:0], '1, '1);
  endtask

  // Extremes on the full grid: a maximal hill in the corner, saturation,
  // a zero radius, reads outside the grid and the unused mode.
  task automatic test_full_grid_extremes();
    read_cell(0, 0);
    send_item(MODE_HILL, -10'sd1, -10'sd1, 6'd63, 18'h3FFFF);
    read_cell(0, 0);
    read_cell(30, 20);
    send_item(MODE_HILL, 10'sd100, 10'sd100, 6'd4, 18'h3FFFF);
    send_item(MODE_HILL, 10'sd100, 10'sd100, 6'd4, 18'd70000);
    read_cell(100, 100);
    read_cell(101, 98);
    send_item(MODE_HILL, 10'sd255, 10'sd255, 6'd3, 18'd40000);
    send_item(MODE_HILL, 10'sd50, 10'sd50, 6'd0, 18'h3FFFF);
    read_cell(50, 50);
    read_cell(255, 255);
    read_cell(-1, 0);
    read_cell(0, 256);
    read_cell(256, 3);
    send_item(MODE_UNUSED, 10'sd100, 10'sd100, 6'd5, 18'h3FFFF);
    read_cell(100, 100);
  endtask

  // Small grid sizes, a size of zero and sizes beyond the grid.
  task automatic test_grid_sizes();
    write_size(CFG_ROWS, 9'd8);
    write_size(CFG_COLS, 9'd8);
    send_item(MODE_HILL, 10'sd4, 10'sd4, 6'd63, 18'd50000);
    read_cell(4, 4);
    read_cell(7, 7);
    read_cell(8, 8);
    read_cell(100, 100);
    write_size(CFG_ROWS, 9'd0);
    send_item(MODE_HILL, 10'sd0, 10'sd0, 6'd2, 18'd1000);
    read_cell(0, 0);
    write_size(CFG_ROWS, 9'd511);
    write_size(CFG_COLS, 9'd1);
    send_item(MODE_HILL, 10'sd0, 10'sd0, 6'd2, 18'd1000);
    read_cell(0, 0);
    read_cell(1, 0);
    write_size(CFG_COLS, 9'd256);
    read_cell(100, 100);
    read_cell(255, 0);
  endtask

  task automatic test_clear();
    send_item(MODE_CLEAR, 10'sd5, -10'sd3, 6'd63, 18'h3FFFF);
    read_cell(100, 100);
    read_cell(0, 0);
  endtask

  // Well-formed work: hills followed by reads close to the last center,
  // with some reads anywhere, odd fields and an occasional clear.
  task automatic random_item(int near_r, int near_c, output int cr, output int cc);
    int pick;
    logic [RAD_W-1:0] rad;
    pick = $urandom_range(0, 99);
    if (pick < 5) cr = $urandom_range(0, 1023) - 512;
    else cr = $urandom_range(0, 257) - 1;
    cc = (pick < 5) ? $urandom_range(0, 1023) - 512 : $urandom_range(0, 257) - 1;
    if (pick < 40) begin
      rad = ($urandom_range(0, 19) == 0) ? RAD_W'($urandom_range(9, 20))
                                          : RAD_W'($urandom_range(0, 8));
      send_item(MODE_HILL, cr[POS_W-1:0], cc[POS_W-1:0], rad,
                PEAK_W'($urandom_range(0, 262143)));
    end else if (pick < 85) begin
      cr = near_r + $urandom_range(0, 16) - 8;
      cc = near_c + $urandom_range(0, 16) - 8;
      send_item(MODE_READ, cr[POS_W-1:0], cc[POS_W-1:0], RAD_W'($urandom),
                PEAK_W'($urandom));
    end else if (pick < 95) begin
      send_item(MODE_READ, cr[POS_W-1:0], cc[POS_W-1:0], RAD_W'($urandom),
                PEAK_W'($urandom));
    end else if (pick < 98) begin
      send_item(MODE_UNUSED, cr[POS_W-1:0], cc[POS_W-1:0], RAD_W'($urandom),
                PEAK_W'($urandom));
    end else begin
      send_item(MODE_CLEAR, POS_W'($urandom), POS_W'($urandom), RAD_W'($urandom),
                PEAK_W'($urandom));
    end
  endtask

  task automatic test_random();
    int hr, hc, nr, nc;
    hr = 128;
    hc = 128;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: begin
          write_size(CFG_ROWS, CFG_W'($urandom_range(1, 255)));
          write_size(CFG_COLS, CFG_W'($urandom_range(1, 255)));
        end
        2: begin
          write_size(CFG_ROWS, 9'd256);
          write_size(CFG_COLS, 9'd256);
        end
        3: begin
          write_size(CFG_ROWS, 9'd1);
          write_size(CFG_COLS, 9'd511);
        end
        default: begin
        end
      endcase
      // The second phase runs with no gaps on the sender.
      no_idle = (phase == 1);
      for (int i = 0; i < 15; i++) begin
        random_item(hr, hc, nr, nc);
        if (in_ch.mode == MODE_HILL) begin
          hr = nr;
          hc = nc;
        end
      end
    end
    no_idle = 1'b0;
    drain();
  endtask

  // The receiver stops for a long stretch while reads keep coming, so the
  // queue inside the block fills and its input stalls.
  task automatic test_backpressure();
    drain();
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) read_cell(100 + i, 100);
    drain();
  endtask

  // Receiver: random readiness and long holds on request.
  initial begin : receiver
    int hold_cnt;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_cnt = 0;
        out_ch.ready = 1'b0;
        while (hold_cnt < 400) begin
          @(negedge clk);
          hold_cnt++;
        end
        hold_req = 1'b0;
      end
      out_ch.ready = no_idle || ($urandom_range(0, 99) >= 25);
    end
  end

  // Each transaction on out_ch is checked against the oldest expectation.
  always @(posedge clk) begin
    cell_result_t exp_res;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_cells.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected result: cell %0d mode %0d", out_ch.cell_height,
                   out_ch.done_mode);
      end else begin
        exp_res = expected_cells.pop_front();
        if (out_ch.cell_height !== exp_res.height || out_ch.done_mode !== exp_res.mode) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected cell %0d mode %0d, got cell %0d mode %0d",
                     exp_res.height, exp_res.mode, out_ch.cell_height, out_ch.done_mode);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel. The clearing
  // pass after reset stays well inside the limit.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_CLEAR;
    in_ch.center_row  = '0;
    in_ch.center_col  = '0;
    in_ch.radius      = '0;
    in_ch.peak_height = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_ROWS;
    cfg_ch.data       = '0;
    foreach (grid_model[i]) grid_model[i] = '0;
    rows_reg = 9'd256;
    cols_reg = 9'd256;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_full_grid_extremes();
    test_grid_sizes();
    test_clear();
    test_backpressure();
    test_random();

    drain();
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
